>>> rtl/i8rsmv_pkg.sv
`timescale 1ns / 1ps
package i8rsmv_pkg;

	localparam int DEFAULT_VECTOR_LENGTH = 1024;
	localparam int DEFAULT_ACC_WIDTH = 40;
	localparam int QUEUE_DEPTH = 4;

	localparam int COLUMN_W = 10;
	localparam int ACT_W = 16;
	localparam int WEIGHT_W = 8;
	localparam int ROW_W = 16;
	localparam int SCALE_W = 16;
	localparam int PROD_W = ACT_W + WEIGHT_W;
	localparam int RESULT_W = 32;

	typedef enum logic {
		OP_LOAD_ACT = 1'b0,
		OP_WEIGHT   = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        opcode;
		logic [COLUMN_W-1:0]        column;
		logic signed [ACT_W-1:0]    activation;
		logic signed [WEIGHT_W-1:0] weight;
		logic [ROW_W-1:0]           row;
		logic [SCALE_W-1:0]         row_scale;
		logic                       last_in_row;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]           row_index;
		logic signed [RESULT_W-1:0] product;
		logic                       saturated;
	} out_item_t;

	// one weight with its activation already fetched
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic signed [ACT_W-1:0]    act;
		logic [ROW_W-1:0]           row;
		logic [SCALE_W-1:0]         row_scale;
		logic                       last_in_row;
	} work_item_t;

endpackage

>>> rtl/int8_row_scaled_matvec_top.sv
`timescale 1ns / 1ps
// int8 weight matrix times a stored Q3.12 activation vector, scaled per row.
// Input channel (in_valid/in_ready/in_data): opcode OP_LOAD_ACT writes one
// activation element at column; OP_WEIGHT brings one weight of the current
// row. The weight with last_in_row set closes the row and yields one result.
// Output channel (out_valid/out_ready/out_data): row_index, the scaled,
// rounded and saturated row sum, and a saturation flag.
// Throughput: one input transfer per cycle while out_ready does not stall
// the back end, set by the single-port activation memory read and the
// one-MAC-per-cycle back end. After the transfer of the row's last weight,
// a result reaches out_valid through the front read stage, the queue, and
// the multiply, accumulate, scale and round/saturate registers.
// Reset: the row accumulator clears and the queue empties; the activation
// store is not cleared, so every element must be written before it is used.
// Receiver stall: the back end holds its stages, the 4-entry queue and the
// front stage absorb further weights, then in_ready drops. Activation loads
// pass while the front stage is empty or draining.
module int8_row_scaled_matvec_top import i8rsmv_pkg::*; #(
	parameter int VECTOR_LENGTH = DEFAULT_VECTOR_LENGTH,
	parameter int ACC_WIDTH = DEFAULT_ACC_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic       push_valid;
	logic       push_ready;
	work_item_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	work_item_t pop_data;

	i8rsmv_front #(
		.VECTOR_LENGTH(VECTOR_LENGTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	i8rsmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	i8rsmv_back #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

>>> rtl/i8rsmv_front.sv
`timescale 1ns / 1ps
module i8rsmv_front import i8rsmv_pkg::*; #(
	parameter int VECTOR_LENGTH = DEFAULT_VECTOR_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       push_valid,
	input  logic       push_ready,
	output work_item_t push_data
);

	localparam int MEM_DEPTH = (VECTOR_LENGTH < (1 << COLUMN_W)) ? VECTOR_LENGTH
		: (1 << COLUMN_W);
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic signed [ACT_W-1:0] act_mem [MEM_DEPTH];

	logic                       valid_s1;
	logic signed [ACT_W-1:0]    rd_s1;
	logic                       in_range_s1;
	logic signed [WEIGHT_W-1:0] weight_s1;
	logic [ROW_W-1:0]           row_s1;
	logic [SCALE_W-1:0]         scale_s1;
	logic                       last_s1;

	logic          xfer;
	logic          in_range;
	logic [AW-1:0] idx;

	assign in_ready = !valid_s1 || push_ready;
	assign xfer     = in_valid && in_ready;
	assign in_range = 32'(in_data.column) < VECTOR_LENGTH;
	assign idx      = in_data.column[AW-1:0];

	always_ff @(posedge clk) begin
		if (xfer && in_range) begin
			if (in_data.opcode == OP_LOAD_ACT) begin
				act_mem[idx] <= in_data.activation;
			end else begin
				rd_s1 <= act_mem[idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && in_data.opcode == OP_WEIGHT) begin
			in_range_s1 <= in_range;
			weight_s1   <= in_data.weight;
			row_s1      <= in_data.row;
			scale_s1    <= in_data.row_scale;
			last_s1     <= in_data.last_in_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (xfer && in_data.opcode == OP_WEIGHT) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// columns past the vector read as zero
	always_comb begin
		push_valid            = valid_s1;
		push_data.weight      = weight_s1;
		push_data.act         = in_range_s1 ? rd_s1 : '0;
		push_data.row         = row_s1;
		push_data.row_scale   = scale_s1;
		push_data.last_in_row = last_s1;
	end

endmodule

>>> rtl/i8rsmv_queue.sv
`timescale 1ns / 1ps
module i8rsmv_queue import i8rsmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  work_item_t push_data,
	output logic       pop_valid,
	input  logic       pop_ready,
	output work_item_t pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	work_item_t        entry_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/i8rsmv_back.sv
`timescale 1ns / 1ps
module i8rsmv_back import i8rsmv_pkg::*; #(
	parameter int ACC_WIDTH = DEFAULT_ACC_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  work_item_t pop_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	// signed sum times a 17-bit non-negative scale
	localparam int SW = ACC_WIDTH + SCALE_W + 1;
	localparam logic signed [SW-1:0] HALF_LSB = SW'(32'sd32768);
	localparam logic signed [SW-1:0] MAX_RES = SW'(32'sh7fffffff);
	localparam logic signed [SW-1:0] MIN_RES = -(MAX_RES + SW'(1));

	logic advance;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [ROW_W-1:0]         row_s1;
	logic [SCALE_W-1:0]       scale_s1;
	logic                     last_s1;

	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ACC_WIDTH-1:0] acc_next;

	logic                        valid_s2;
	logic signed [ACC_WIDTH-1:0] sum_s2;
	logic [ROW_W-1:0]            row_s2;
	logic [SCALE_W-1:0]          scale_s2;

	logic                 valid_s3;
	logic signed [SW-1:0] scaled_s3;
	logic [ROW_W-1:0]     row_s3;

	logic signed [SW-1:0] rounded;
	logic                 over;
	logic                 under;
	out_item_t            result;
	out_item_t            out_q;
	logic                 out_valid_q;

	assign advance   = !out_valid_q || out_ready;
	assign pop_ready = advance;
	assign acc_next  = acc_q + ACC_WIDTH'(prod_s1);

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1  <= PROD_W'(pop_data.weight) * PROD_W'(pop_data.act);
			row_s1   <= pop_data.row;
			scale_s1 <= pop_data.row_scale;
			last_s1  <= pop_data.last_in_row;
			sum_s2   <= acc_next;
			row_s2   <= row_s1;
			scale_s2 <= scale_s1;
			scaled_s3 <= SW'(sum_s2) * SW'($signed({1'b0, scale_s2}));
			row_s3   <= row_s2;
			out_q    <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (advance) begin
			valid_s1    <= pop_valid;
			valid_s2    <= valid_s1 && last_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s1) begin
				acc_q <= last_s1 ? '0 : acc_next;
			end
		end
	end

	// round half up, then floor divide by 2^16
	always_comb begin
		rounded          = (scaled_s3 + HALF_LSB) >>> 16;
		over             = rounded > MAX_RES;
		under            = rounded < MIN_RES;
		result.row_index = row_s3;
		result.saturated = over || under;
		priority if (over) begin
			result.product = MAX_RES[RESULT_W-1:0];
		end else if (under) begin
			result.product = MIN_RES[RESULT_W-1:0];
		end else begin
			result.product = rounded[RESULT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/i8rsmv_checker.sv
`timescale 1ns / 1ps
module i8rsmv_checker import i8rsmv_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.product == 32'sh7fffffff || out_data.product == 32'sh80000000))
		else $error("saturated result not at a range limit");

	// the queue only fills while the output is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("in_ready low without an output stall");

endmodule

bind int8_row_scaled_matvec_top i8rsmv_checker u_checker (.*);
